@@ hdl/alist_pkg.sv @@
// ---------------------------------------------------------------------------
// alist_pkg: shared types for the array list engine
// Operation codes and sequencer states used by the list controller.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package alist_pkg;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_SEARCH = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ hdl/alist_store.sv @@
// ---------------------------------------------------------------------------
// alist_store: entry memory of the array list engine
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module alist_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  wire                  clk,
  input  wire                  wr_en,
  input  wire  [AW-1:0]        wr_addr,
  input  wire  signed [31:0]   wr_data,
  input  wire  [AW-1:0]        rd_addr,
  output logic signed [31:0]   rd_data
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ hdl/array_list_engine.sv @@
// ---------------------------------------------------------------------------
// array_list_engine: fixed-capacity ordered list of signed 32-bit values
// A small sequencer drives one memory with a write and a read port to append,
// insert in order, remove the first match and search the list.
// ---------------------------------------------------------------------------
// Each transaction carries an operation and a value and yields one result
// with success, position and the entry count afterwards. Append, insert
// into an empty list and any operation that fails at once on a full or
// empty list go straight to the done state. Search and remove walk the
// stored entries through the single memory read port, one entry per cycle.
// Sorted insert moves entries up from the tail towards the head until it
// finds the place of the new value. The input is not ready while an
// operation is in progress; a finished result waits in its output register
// without blocking the next transaction, but the next result stays in the
// done state until the previous one is taken. Entries need no clearing
// after reset, since only entries below the count are read.
`timescale 1ns / 1ps
`default_nettype none

module array_list_engine #(
  parameter int CAPACITY = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [1:0]          op,
  input  wire  signed [31:0]  value,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic                success,
  output logic [3:0]          position,
  output logic [4:0]          entry_count
);

  import alist_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  state_t state, state_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] cnt, cnt_next;
  logic ok, ok_next;
  op_t op_q;
  logic signed [31:0] val_q;

  logic wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic signed [31:0] wr_data, rd_data;
  logic out_load;

  logic [CW:0] ptr_p1, ptr_p2;
  logic [CW+4:0] cnt_wide, pos_wide;

  assign ptr_p1 = {1'b0, ptr} + {{CW{1'b0}}, 1'b1};
  assign ptr_p2 = {1'b0, ptr} + (CW+1)'(2);
  assign in_ready = (state == ST_IDLE);

  alist_store #(
    .DEPTH(CAPACITY),
    .AW   (AW)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    pos <= pos_next;
    ok  <= ok_next;
    if (in_valid && in_ready) begin
      op_q  <= op_t'(op);
      val_q <= value;
    end
  end

  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    pos_next   = pos;
    ok_next    = ok;
    cnt_next   = cnt;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = rd_data;
    rd_addr    = '0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          ok_next  = 1'b0;
          pos_next = '0;
          case (op_t'(op))
            OP_APPEND: begin
              state_next = ST_DONE;
              if (cnt < CAP_C) begin
                wr_en    = 1'b1;
                wr_addr  = cnt[AW-1:0];
                wr_data  = value;
                ok_next  = 1'b1;
                pos_next = cnt;
                cnt_next = cnt + 1'b1;
              end
            end
            OP_INSERT: begin
              if (cnt == CAP_C) begin
                state_next = ST_DONE;
              end else if (cnt == '0) begin
                wr_en      = 1'b1;
                wr_addr    = '0;
                wr_data    = value;
                ok_next    = 1'b1;
                cnt_next   = cnt + 1'b1;
                state_next = ST_DONE;
              end else begin
                rd_addr    = AW'(cnt - 1'b1);
                ptr_next   = cnt;
                state_next = ST_INS;
              end
            end
            default: begin
              if (cnt == '0) begin
                state_next = ST_DONE;
              end else begin
                ptr_next   = '0;
                state_next = ST_SCAN;
              end
            end
          endcase
        end
      end
      ST_INS: begin
        wr_en   = 1'b1;
        wr_addr = ptr[AW-1:0];
        if (ptr == '0 || !(rd_data > val_q)) begin
          wr_data    = val_q;
          ok_next    = 1'b1;
          pos_next   = ptr;
          cnt_next   = cnt + 1'b1;
          state_next = ST_DONE;
        end else begin
          wr_data  = rd_data;
          ptr_next = ptr - 1'b1;
          rd_addr  = (ptr > CW'(1)) ? AW'(ptr - CW'(2)) : '0;
        end
      end
      ST_SCAN: begin
        if (rd_data == val_q) begin
          ok_next  = 1'b1;
          pos_next = ptr;
          if (op_q == OP_SEARCH) begin
            state_next = ST_DONE;
          end else if (ptr_p1 < {1'b0, cnt}) begin
            rd_addr    = ptr_p1[AW-1:0];
            state_next = ST_SHIFT;
          end else begin
            cnt_next   = cnt - 1'b1;
            state_next = ST_DONE;
          end
        end else if (ptr_p1 < {1'b0, cnt}) begin
          rd_addr  = ptr_p1[AW-1:0];
          ptr_next = ptr_p1[CW-1:0];
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_SHIFT: begin
        wr_en    = 1'b1;
        wr_addr  = ptr[AW-1:0];
        wr_data  = rd_data;
        ptr_next = ptr_p1[CW-1:0];
        if (ptr_p2 < {1'b0, cnt}) begin
          rd_addr = ptr_p2[AW-1:0];
        end else begin
          cnt_next   = cnt - 1'b1;
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign cnt_wide = {5'b0, cnt};
  assign pos_wide = {5'b0, pos};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      success     <= ok;
      position    <= pos_wide[3:0];
      entry_count <= cnt_wide[4:0];
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CAP_C)
    else $error("Entry count exceeds capacity.");

  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SHIFT) |-> (ptr_p1 < {1'b0, cnt}))
    else $error("Remove shift runs past the last entry.");

  a_write_range: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> ({1'b0, wr_addr} < (AW+1)'(CAPACITY)))
    else $error("Write address beyond capacity.");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("Input accepted again before the operation finished.");

  a_fail_pos: assert property (@(posedge clk) disable iff (rst)
    (out_load && !ok) |-> (pos == '0))
    else $error("Failed operation reports a nonzero position.");

endmodule

`default_nettype wire

@@ dv/array_list_checker.sv @@
// ---------------------------------------------------------------------------
// array_list_checker: result predictor and scoreboard for array_list_engine
// Watches both channels, keeps its own copy of the list, predicts the result
// of each accepted transaction and compares every accepted result with it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module array_list_checker #(
  parameter int CAPACITY = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  input  wire                in_ready,
  input  wire         [1:0]  op,
  input  wire  signed [31:0] value,
  input  wire                out_valid,
  input  wire                out_ready,
  input  wire                success,
  input  wire         [3:0]  position,
  input  wire         [4:0]  entry_count,
  output int                 mismatch_count,
  output int                 results_due
);

  import alist_pkg::*;

  typedef struct packed {
    logic       success;
    logic [3:0] position;
    logic [4:0] entry_count;
  } list_result_t;

  logic signed [31:0] list_store [CAPACITY];
  int                 list_len;
  list_result_t       expected_results [$];

  function automatic list_result_t apply_op(op_t o, logic signed [31:0] v);
    list_result_t r;
    int           gap;
    int           idx;
    int           j;
    bit           hit;
    r = '0;
    idx = 0;
    hit = 0;
    case (o)
      OP_APPEND: begin
        if (list_len < CAPACITY) begin
          list_store[list_len] = v;
          r.position = list_len[3:0];
          r.success = 1'b1;
          list_len++;
        end
      end
      OP_INSERT: begin
        if (list_len < CAPACITY) begin
          gap = list_len;
          while (gap > 0 && list_store[gap-1] > v) begin
            list_store[gap] = list_store[gap-1];
            gap--;
          end
          list_store[gap] = v;
          r.position = gap[3:0];
          r.success = 1'b1;
          list_len++;
        end
      end
      default: begin
        for (j = 0; j < list_len && !hit; j++) begin
          if (list_store[j] == v) begin
            hit = 1;
            idx = j;
          end
        end
        if (hit) begin
          r.success = 1'b1;
          r.position = idx[3:0];
          if (o == OP_REMOVE) begin
            for (j = idx; j + 1 < list_len; j++) list_store[j] = list_store[j+1];
            list_len--;
          end
        end
      end
    endcase
    r.entry_count = list_len[4:0];
    return r;
  endfunction

  initial begin
    mismatch_count = 0;
    results_due = 0;
    list_len = 0;
  end

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      list_len = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no expected result waiting");
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (success !== want.success) begin
            $error("success: expected %0d, actual %0d", want.success, success);
            mismatch_count++;
          end
          if (position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, position);
            mismatch_count++;
          end
          if (entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d",
                   want.entry_count, entry_count);
            mismatch_count++;
          end
        end
      end
      if (in_valid && in_ready) expected_results.push_back(apply_op(op_t'(op), value));
    end
    results_due = expected_results.size();
  end

endmodule

@@ dv/array_list_engine_test.sv @@
// ---------------------------------------------------------------------------
// array_list_engine_test: top of the array list engine testbench
// Drives directed and random list operations with random idling on both
// channels, one long output hold-off, and a watchdog on stalled handshakes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module array_list_engine_test;
  import alist_pkg::*;

  localparam int CAPACITY    = 16;
  localparam int RANDOM_OPS  = 1025;
  localparam int STALL_LIMIT = 3000;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic        [1:0]  op;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_ready;
  logic               success;
  logic        [3:0]  position;
  logic        [4:0]  entry_count;
  int                 mismatch_count;
  int                 results_due;
  int                 sent_count;
  bit                 quiet;
  logic signed [31:0] value_pool [8];

  array_list_engine #(.CAPACITY(CAPACITY)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .success(success), .position(position), .entry_count(entry_count)
  );

  array_list_checker #(.CAPACITY(CAPACITY)) list_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .op(op), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .success(success), .position(position), .entry_count(entry_count),
    .mismatch_count(mismatch_count), .results_due(results_due)
  );

  assign quiet = (sent_count >= 500 && sent_count < 700);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_item(input op_t o, input logic signed [31:0] v);
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(99) < 75) return value_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  function automatic op_t pick_op(bit filling);
    int r;
    r = $urandom_range(99);
    if (filling) begin
      if (r < 30) return OP_APPEND;
      if (r < 65) return OP_INSERT;
      if (r < 80) return OP_REMOVE;
      return OP_SEARCH;
    end
    if (r < 10) return OP_APPEND;
    if (r < 25) return OP_INSERT;
    if (r < 70) return OP_REMOVE;
    return OP_SEARCH;
  endfunction

  // Receiver: random back-pressure, plus one long hold-off so that the
  // engine fills its result register and stops taking new transactions.
  initial begin
    int  hold_left;
    bit  held;
    hold_left = 0;
    held = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && sent_count >= 300) begin
        held = 1;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= rst ? 1'b0 : (quiet || $urandom_range(99) >= 18);
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int  i;
    int  phase_left;
    bit  filling;
    rst = 1'b1;
    in_valid = 1'b0;
    op = '0;
    value = '0;
    sent_count = 0;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 32'sh0000_0000;
    value_pool[3] = -32'sd1;
    for (i = 4; i < 8; i++) value_pool[i] = $urandom;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(OP_SEARCH, 32'sd0);
    send_item(OP_REMOVE, 32'sd0);
    send_item(OP_APPEND, 32'sh7fff_ffff);
    send_item(OP_APPEND, 32'sh8000_0000);
    send_item(OP_INSERT, 32'sd0);
    send_item(OP_INSERT, -32'sd5);
    send_item(OP_SEARCH, 32'sh8000_0000);
    send_item(OP_REMOVE, 32'sh7fff_ffff);
    send_item(OP_SEARCH, 32'sh7fff_ffff);
    for (i = 0; i < 13; i++) send_item((i % 2) ? OP_APPEND : OP_INSERT, $urandom);
    send_item(OP_APPEND, -32'sd1);
    send_item(OP_INSERT, 32'sh8000_0000);
    send_item(OP_REMOVE, 32'sh1234_5679);

    filling = 1;
    phase_left = 40;
    for (i = 0; i < RANDOM_OPS; i++) begin
      if (phase_left == 0) begin
        filling = !filling;
        phase_left = $urandom_range(60, 25);
      end
      phase_left--;
      if ($urandom_range(99) == 0) value_pool[$urandom_range(7, 4)] = $urandom;
      send_item(pick_op(filling), pick_value());
    end
    @(negedge clk);
    in_valid <= 1'b0;

    while (results_due != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/alist_pkg.sv
hdl/alist_store.sv
hdl/array_list_engine.sv
dv/array_list_checker.sv
dv/array_list_engine_test.sv
